// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/bdte_pkg.sv -----
// Shared constants and calendar helpers for the broken-down time converter.
`default_nettype none
package bdte_pkg;

  localparam int TIME_BITS = 32;
  localparam int S_W       = TIME_BITS + 8;
  localparam int EPOCH_W   = 32;

  localparam int MUL_AW = 20;
  localparam int MUL_BW = 19;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BIAS    = 1'd1;

  // Reciprocals: floor(x*M>>SH) is exact for RCP25 here, may be one low for RCP7.
  localparam logic [MUL_BW-1:0] RCP25     = 19'd1311;
  localparam int                RCP25_SH  = 15;
  localparam logic [MUL_BW-1:0] RCP7      = 19'd299593;
  localparam int                RCP7_SH   = 21;
  localparam logic [MUL_BW-1:0] DAYS_YEAR = 19'd365;
  localparam logic [MUL_BW-1:0] SEC_DAY   = 19'd86400;

  localparam logic signed [12:0] YEAR_BIAS25 = 13'sd1100;  // multiple of 25
  localparam logic signed [12:0] YEAR_PREV   = 13'sd1899;  // full year minus one
  localparam logic signed [11:0] YEAR_EPOCH  = 12'sd70;
  localparam logic [19:0]        LEAPS_1969  = 20'd477;

  // year is years since 1900; r25 is year mod 25 (1900 is a multiple of 25 and 4)
  function automatic logic is_leap(logic signed [11:0] year, logic [4:0] r25);
    logic [11:0] y16;
    y16 = year + 12'sd12;  // 1900 mod 16 is 12
    return (year[1:0] == 2'd0) && ((r25 != 5'd0) || (y16[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] mon, logic leap);
    logic [4:0] d;
    case (mon)
      4'd0:    d = 5'd31;
      4'd1:    d = leap ? 5'd29 : 5'd28;
      4'd2:    d = 5'd31;
      4'd3:    d = 5'd30;
      4'd4:    d = 5'd31;
      4'd5:    d = 5'd30;
      4'd6:    d = 5'd31;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd30;
      4'd9:    d = 5'd31;
      4'd10:   d = 5'd30;
      4'd11:   d = 5'd31;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- src/bdte_mul.sv -----
// Shared registered multiplier used by the sequencer.
`default_nettype none
module bdte_mul (
  input  wire logic                       clk,
  input  wire logic [bdte_pkg::MUL_AW-1:0] a,
  input  wire logic [bdte_pkg::MUL_BW-1:0] b,
  output logic      [bdte_pkg::MUL_PW-1:0] prod
);
  import bdte_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule
`default_nettype wire

// ----- src/broken_down_time_to_epoch.sv -----
// Broken-down date and time to seconds since 1970, with field normalization.
//
// The block accepts no new item while a transaction is in progress. Seconds,
// minutes, hours and months are carried one step per cycle. The day count then
// walks one month per cycle, and day_of_year sums one month per cycle. A single
// shared multiplier does all reciprocal divisions and the day and year scalings.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module broken_down_time_to_epoch (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [bdte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdte_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [10:0]                  in_second,
  input  wire logic signed [10:0]                  in_minute,
  input  wire logic signed [10:0]                  in_hour,
  input  wire logic signed [10:0]                  in_day_of_month,
  input  wire logic signed [7:0]                   in_month,
  input  wire logic signed [10:0]                  in_year,
  input  wire logic                                daylight_flag,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [bdte_pkg::EPOCH_W-1:0]      epoch_seconds,
  output logic [5:0]                               out_second,
  output logic [5:0]                               out_minute,
  output logic [4:0]                               out_hour,
  output logic [4:0]                               out_day_of_month,
  output logic [3:0]                               out_month,
  output logic signed [11:0]                       out_year,
  output logic [8:0]                               day_of_year,
  output logic [2:0]                               weekday
);
  import bdte_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_SEC  = 20'h00002,
    ST_MIN  = 20'h00004,
    ST_HOUR = 20'h00008,
    ST_MON  = 20'h00010,
    ST_R25A = 20'h00020,
    ST_R25B = 20'h00040,
    ST_DNEG = 20'h00080,
    ST_DPOS = 20'h00100,
    ST_YDAY = 20'h00200,
    ST_M1   = 20'h00400,
    ST_M2   = 20'h00800,
    ST_M3   = 20'h01000,
    ST_M4   = 20'h02000,
    ST_M5   = 20'h04000,
    ST_M6   = 20'h08000,
    ST_M7   = 20'h10000,
    ST_M8   = 20'h20000,
    ST_M9   = 20'h40000,
    ST_DONE = 20'h80000
  } state_t;

  localparam logic signed [S_W-1:0] TMAX =
    {{(S_W-TIME_BITS+1){1'b0}}, {(TIME_BITS-1){1'b1}}};

  state_t state;

  logic signed [17:0] zone_offset;
  logic [12:0]        dst_bias;

  logic signed [11:0] sec, mins, hrs, day, year;
  logic signed [7:0]  mon;
  logic               dst_on;
  logic [4:0]         r25;
  logic [3:0]         m_cnt;
  logic [8:0]         yday;
  logic [2:0]         wday;
  logic [16:0]        sod;
  logic [7:0]         t100, t400;
  logic [18:0]        days;
  logic signed [S_W-1:0] s;
  logic               bad;
  logic signed [S_W-1:0] res_epoch;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] prod;

  // month walk helpers
  logic              leap_cur, leap_dec;
  logic [4:0]        dim_cur, dim_dec;
  logic [3:0]        mon_dec, mon_inc;
  logic signed [11:0] year_dec, year_inc;
  logic [4:0]        r25_dec, r25_inc;
  logic signed [12:0] year_x, n13;
  logic [7:0]        q25;
  logic [12:0]       q25x25, r25_full;
  logic [19:0]       d4, q7x7, r7_full, days_sum;
  logic [16:0]       q7;
  logic [3:0]        r7;
  logic signed [S_W-1:0] s_sum, s_zone, s_dst;

  bdte_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    leap_cur = is_leap(year, r25);
    dim_cur  = days_in(mon[3:0], leap_cur);
    if (mon[3:0] == 4'd0) begin
      mon_dec  = 4'd11;
      year_dec = year - 12'sd1;
      r25_dec  = (r25 == 5'd0) ? 5'd24 : r25 - 5'd1;
    end else begin
      mon_dec  = mon[3:0] - 4'd1;
      year_dec = year;
      r25_dec  = r25;
    end
    if (mon[3:0] == 4'd11) begin
      mon_inc  = 4'd0;
      year_inc = year + 12'sd1;
      r25_inc  = (r25 == 5'd24) ? 5'd0 : r25 + 5'd1;
    end else begin
      mon_inc  = mon[3:0] + 4'd1;
      year_inc = year;
      r25_inc  = r25;
    end
    leap_dec = is_leap(year_dec, r25_dec);
    dim_dec  = days_in(mon_dec, leap_dec);

    year_x   = {year[11], year} + YEAR_BIAS25;
    n13      = {year[11], year} + YEAR_PREV;
    q25      = prod[RCP25_SH+7:RCP25_SH];
    q25x25   = {1'b0, q25, 4'b0} + {2'b0, q25, 3'b0} + {5'b0, q25};
    r25_full = year_x - q25x25;

    d4       = {1'b0, days} + 20'd4;
    q7       = prod[RCP7_SH+16:RCP7_SH];
    q7x7     = {q7, 3'b0} - {3'b0, q7};
    r7_full  = d4 - q7x7;
    r7       = r7_full[3:0];

    days_sum = {1'b0, prod[18:0]} + {9'b0, n13[12:2]} - {12'b0, t100}
             + {12'b0, t400} - LEAPS_1969 + {11'b0, yday};

    s_sum  = {{(S_W-MUL_PW){1'b0}}, prod} + {{(S_W-17){1'b0}}, sod};
    s_zone = s + {{(S_W-18){zone_offset[17]}}, zone_offset};
    s_dst  = s - (dst_on ? {{(S_W-13){1'b0}}, dst_bias} : {S_W{1'b0}});

    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_R25A: begin
        mul_a = {{(MUL_AW-13){1'b0}}, year_x};
        mul_b = RCP25;
      end
      ST_M1: begin
        mul_a = {{(MUL_AW-11){1'b0}}, n13[12:2]};
        mul_b = RCP25;
      end
      ST_M2: begin
        mul_a = {{(MUL_AW-9){1'b0}}, n13[12:4]};
        mul_b = RCP25;
      end
      ST_M3: begin
        mul_a = {{(MUL_AW-12){1'b0}}, year - YEAR_EPOCH};
        mul_b = DAYS_YEAR;
      end
      ST_M5: begin
        mul_a = d4;
        mul_b = RCP7;
      end
      ST_M6: begin
        mul_a = {{(MUL_AW-19){1'b0}}, days};
        mul_b = SEC_DAY;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
      dst_bias    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZONE_OFFSET: zone_offset <= cfg_data;
        REG_DST_BIAS:    dst_bias    <= cfg_data[12:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sec    <= {in_second[10], in_second};
            mins   <= {in_minute[10], in_minute};
            hrs    <= {in_hour[10], in_hour};
            day    <= {in_day_of_month[10], in_day_of_month} - 12'sd1;
            mon    <= in_month;
            year   <= {in_year[10], in_year};
            dst_on <= daylight_flag;
            state  <= ST_SEC;
          end
        end
        ST_SEC: begin
          if (sec < 0) begin
            sec  <= sec + 12'sd60;
            mins <= mins - 12'sd1;
          end else if (sec >= 12'sd60) begin
            sec  <= sec - 12'sd60;
            mins <= mins + 12'sd1;
          end else begin
            state <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (mins < 0) begin
            mins <= mins + 12'sd60;
            hrs  <= hrs - 12'sd1;
          end else if (mins >= 12'sd60) begin
            mins <= mins - 12'sd60;
            hrs  <= hrs + 12'sd1;
          end else begin
            state <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (hrs < 0) begin
            hrs <= hrs + 12'sd24;
            day <= day - 12'sd1;
          end else if (hrs >= 12'sd24) begin
            hrs <= hrs - 12'sd24;
            day <= day + 12'sd1;
          end else begin
            state <= ST_MON;
          end
        end
        ST_MON: begin
          if (mon < 0) begin
            mon  <= mon + 8'sd12;
            year <= year - 12'sd1;
          end else if (mon >= 8'sd12) begin
            mon  <= mon - 8'sd12;
            year <= year + 12'sd1;
          end else begin
            state <= ST_R25A;
          end
        end
        ST_R25A: state <= ST_R25B;
        ST_R25B: begin
          r25   <= r25_full[4:0];
          state <= ST_DNEG;
        end
        ST_DNEG: begin
          if (day < 0) begin
            mon  <= {4'b0, mon_dec};
            year <= year_dec;
            r25  <= r25_dec;
            day  <= day + {7'b0, dim_dec};
          end else begin
            state <= ST_DPOS;
          end
        end
        ST_DPOS: begin
          if (day >= {7'b0, dim_cur}) begin
            day  <= day - {7'b0, dim_cur};
            mon  <= {4'b0, mon_inc};
            year <= year_inc;
            r25  <= r25_inc;
          end else if (year < YEAR_EPOCH) begin
            res_epoch <= '1;
            yday      <= '0;
            wday      <= '0;
            state     <= ST_DONE;
          end else begin
            yday  <= day[8:0];
            m_cnt <= '0;
            state <= ST_YDAY;
          end
        end
        ST_YDAY: begin
          if (m_cnt == mon[3:0]) begin
            state <= ST_M1;
          end else begin
            yday  <= yday + {4'b0, days_in(m_cnt, leap_cur)};
            m_cnt <= m_cnt + 4'd1;
          end
        end
        ST_M1: begin
          sod   <= 17'(hrs[4:0] * 17'd3600) + 17'(mins[5:0] * 17'd60) + {11'b0, sec[5:0]};
          state <= ST_M2;
        end
        ST_M2: begin
          t100  <= q25;
          state <= ST_M3;
        end
        ST_M3: begin
          t400  <= q25;
          state <= ST_M4;
        end
        ST_M4: begin
          days  <= days_sum[18:0];
          state <= ST_M5;
        end
        ST_M5: state <= ST_M6;
        ST_M6: begin
          wday  <= (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];
          state <= ST_M7;
        end
        ST_M7: begin
          s     <= s_sum;
          bad   <= (s_sum > TMAX);
          state <= ST_M8;
        end
        ST_M8: begin
          s     <= s_zone;
          bad   <= bad || (s_zone > TMAX) || (s_zone < 0);
          state <= ST_M9;
        end
        ST_M9: begin
          res_epoch <= (bad || (s_dst < 0)) ? '1 : s_dst;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            epoch_seconds    <= res_epoch[EPOCH_W-1:0];
            out_second       <= sec[5:0];
            out_minute       <= mins[5:0];
            out_hour         <= hrs[4:0];
            out_day_of_month <= day[4:0] + 5'd1;
            out_month        <= mon[3:0];
            out_year         <= year;
            day_of_year      <= yday;
            weekday          <= wday;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/bdte_checker.sv -----
// Port-level checker for the broken-down time converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bdte_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic signed [bdte_pkg::EPOCH_W-1:0] epoch_seconds,
  input wire logic [5:0]                      out_second,
  input wire logic [4:0]                      out_hour,
  input wire logic [3:0]                      out_month,
  input wire logic signed [11:0]              out_year
);
  import bdte_pkg::*;

  // busy right after a transaction is taken
  `AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `AST_NEXT(a_out_holds, out_valid && out_stall, out_valid)
  `AST_IMPL(a_fields_norm, out_valid, out_second < 6'd60 && out_hour < 5'd24 && out_month < 4'd12)
  // a valid time implies a year not before 1970
  `AST_IMPL(a_early_year, out_valid && epoch_seconds != -1, out_year >= 12'sd70)

endmodule

bind broken_down_time_to_epoch bdte_checker u_bdte_checker (.*);
`default_nettype wire
